@@ hw/rtl/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes for the bitmap slot allocator: request kinds, result
// status codes and the control bundles passed between its modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // request kind carried by an input beat
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  // result status
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_NOT_TAKEN = 2'd2;

  // field widths of the beats
  localparam int SLOT_FIELD_W  = 8;
  localparam int COUNT_FIELD_W = 9;

  // bitmap ram port enables
  typedef struct packed {
    logic we;
    logic re;
  } ram_ctrl_t;

  // flags from the word scan unit
  typedef struct packed {
    logic zero_found;
    logic bit_taken;
  } word_flags_t;

endpackage

@@ hw/rtl/bsa_if.sv @@
// ----------------------------------------------------------------------------
// bsa request and result channels
// Valid/ready channels; a beat moves at a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface bsa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [bsa_pkg::SLOT_FIELD_W-1:0] free_slot;

  modport source (output valid, output req_type, output free_slot, input ready);
  modport sink   (input valid, input req_type, input free_slot, output ready);
endinterface

interface bsa_res_if;
  logic                            valid;
  logic                            ready;
  logic [bsa_pkg::SLOT_FIELD_W-1:0]  granted_slot;
  logic [1:0]                      status;
  logic [bsa_pkg::COUNT_FIELD_W-1:0] used_count;
  logic                            pool_full;

  modport source (output valid, output granted_slot, output status, output used_count,
                  output pool_full, input ready);
  modport sink   (input valid, input granted_slot, input status, input used_count,
                  input pool_full, output ready);
endinterface

@@ hw/rtl/bsa_bitmap_ram.sv @@
// ----------------------------------------------------------------------------
// bsa_bitmap_ram
// Bitmap word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_bitmap_ram #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 4,
  parameter int ADDR_W     = 2
) (
  input  logic                  clk,
  input  bsa_pkg::ram_ctrl_t    ctrl,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [WORD_BITS-1:0]  wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [WORD_BITS-1:0]  rdata
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (ctrl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bsa_word_unit.sv @@
// ----------------------------------------------------------------------------
// bsa_word_unit
// Shared word unit: finds the lowest free bit of one bitmap word, tests a
// selected bit, and forms the word with the found free bit set or the selected bit cleared.
// ----------------------------------------------------------------------------
module bsa_word_unit #(
  parameter int WORD_BITS = 64,
  parameter int TAIL_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic                         tail,
  input  logic [$clog2(WORD_BITS)-1:0] bit_sel,
  output bsa_pkg::word_flags_t         flags,
  output logic [$clog2(WORD_BITS)-1:0] zero_pos,
  output logic [WORD_BITS-1:0]         set_word,
  output logic [WORD_BITS-1:0]         clr_word
);
  import bsa_pkg::*;

  localparam int BIT_W = $clog2(WORD_BITS);
  // bits past the end of the pool in the last word count as taken
  localparam logic [WORD_BITS-1:0] TAIL_PAD = {WORD_BITS{1'b1}} << TAIL_BITS;

  logic [WORD_BITS-1:0] scan_word;
  logic                 found;

  assign scan_word = tail ? (word | TAIL_PAD) : word;

  // priority search for the lowest zero
  always_comb begin
    found    = 1'b0;
    zero_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        found    = 1'b1;
        zero_pos = BIT_W'(b);
      end
    end
  end

  // flags: zero found, then the selected bit
  assign flags = {found, word[bit_sel]};

  // bit update
  assign set_word = word | (WORD_BITS'(1) << zero_pos);
  assign clr_word = word & ~(WORD_BITS'(1) << bit_sel);

endmodule

@@ hw/rtl/bitmap_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// Bitmap slot allocator: grants the lowest free slot or releases a given slot.
// ----------------------------------------------------------------------------
// One request at a time, one result beat per request. The bitmap lives in a
// RAM of POOL_SLOTS/WORD_BITS words (rounded up) read one word per cycle, so
// time is set by how many words the sequencer walks: an allocate scans words
// until it finds a free bit (1 to WORD_COUNT words), a free walks to word
// slot/WORD_BITS, and a request on a full pool or of a slot beyond the pool
// walks no words; the result then waits for ready. After reset a clearing
// pass writes every bitmap word to zero, with no request accepted meanwhile.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core #(
  parameter int POOL_SLOTS = 256,
  parameter int WORD_BITS  = 64
) (
  input  logic      clk,
  input  logic      rst,
  bsa_req_if.sink   req,
  bsa_res_if.source res
);
  import bsa_pkg::*;

  localparam int WORD_COUNT = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int TAIL_BITS  = POOL_SLOTS - (WORD_COUNT - 1) * WORD_BITS;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam logic [WIDX_W-1:0]       LAST_IDX  = WIDX_W'(WORD_COUNT - 1);
  localparam logic [CNT_W-1:0]        CNT_FULL  = CNT_W'(POOL_SLOTS);
  localparam logic [SLOT_FIELD_W-1:0] WB_STEP   = SLOT_FIELD_W'(WORD_BITS);
  localparam logic [SLOT_W-1:0]       BASE_STEP = SLOT_W'(WORD_BITS);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [WIDX_W-1:0]       idx, idx_next;
  logic [SLOT_W-1:0]       base, base_next;
  logic [SLOT_FIELD_W-1:0] rem, rem_next;
  logic [CNT_W-1:0]        taken_total, taken_total_next;
  req_kind_t               op;
  logic [SLOT_W-1:0]       granted, granted_next;
  status_t                 status, status_next;
  logic                    load_res;

  ram_ctrl_t               ram_ctrl;
  logic [WIDX_W-1:0]       raddr;
  logic [WORD_BITS-1:0]    wdata;
  logic [WORD_BITS-1:0]    rdata;
  word_flags_t             flags;
  logic [BIT_W-1:0]        zero_pos;
  logic [WORD_BITS-1:0]    set_word;
  logic [WORD_BITS-1:0]    clr_word;
  logic                    req_beat;
  logic                    slot_in_pool;

  assign req.ready    = (state == ST_IDLE);
  assign req_beat     = req.valid && req.ready;
  assign slot_in_pool = (32'(req.free_slot) < POOL_SLOTS);

  bsa_bitmap_ram #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (WIDX_W)
  ) u_ram (
    .clk   (clk),
    .ctrl  (ram_ctrl),
    .waddr (idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bsa_word_unit #(
    .WORD_BITS (WORD_BITS),
    .TAIL_BITS (TAIL_BITS)
  ) u_unit (
    .word     (rdata),
    .tail     (idx == LAST_IDX),
    .bit_sel  (rem[BIT_W-1:0]),
    .flags    (flags),
    .zero_pos (zero_pos),
    .set_word (set_word),
    .clr_word (clr_word)
  );

  // sequencer
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    base_next        = base;
    rem_next         = rem;
    taken_total_next = taken_total;
    granted_next     = '0;
    status_next      = STATUS_OK;
    load_res         = 1'b0;
    ram_ctrl         = '0;
    raddr            = '0;
    wdata            = '0;
    case (state)
      ST_CLEAR: begin
        ram_ctrl.we = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_beat) begin
          idx_next    = '0;
          base_next   = '0;
          rem_next    = req.free_slot;
          ram_ctrl.re = 1'b1;
          if (req.req_type == REQ_ALLOC) begin
            if (taken_total == CNT_FULL) begin
              status_next = STATUS_FULL;
              load_res    = 1'b1;
              state_next  = ST_DONE;
            end else begin
              state_next = ST_CHECK;
            end
          end else if (!slot_in_pool) begin
            status_next = STATUS_NOT_TAKEN;
            load_res    = 1'b1;
            state_next  = ST_DONE;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (op == REQ_ALLOC) begin
          if (flags.zero_found) begin
            ram_ctrl.we      = 1'b1;
            wdata            = set_word;
            granted_next     = base + SLOT_W'(zero_pos);
            taken_total_next = taken_total + 1'b1;
            load_res         = 1'b1;
            state_next       = ST_DONE;
          end else if (idx == LAST_IDX) begin
            status_next = STATUS_FULL;
            load_res    = 1'b1;
            state_next  = ST_DONE;
          end else begin
            ram_ctrl.re = 1'b1;
            raddr       = idx + 1'b1;
            idx_next    = idx + 1'b1;
            base_next   = base + BASE_STEP;
          end
        end else begin
          if (rem >= WB_STEP) begin
            ram_ctrl.re = 1'b1;
            raddr       = idx + 1'b1;
            idx_next    = idx + 1'b1;
            rem_next    = rem - WB_STEP;
          end else if (flags.bit_taken) begin
            ram_ctrl.we      = 1'b1;
            wdata            = clr_word;
            taken_total_next = taken_total - 1'b1;
            load_res         = 1'b1;
            state_next       = ST_DONE;
          end else begin
            status_next = STATUS_NOT_TAKEN;
            load_res    = 1'b1;
            state_next  = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      idx         <= '0;
      taken_total <= '0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      taken_total <= taken_total_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    base <= base_next;
    rem  <= rem_next;
    if (req_beat) begin
      op <= req_kind_t'(req.req_type);
    end
    if (load_res) begin
      granted <= granted_next;
      status  <= status_next;
    end
  end

  // result beat
  assign res.valid        = (state == ST_DONE);
  assign res.granted_slot = SLOT_FIELD_W'(granted);
  assign res.status       = status;
  assign res.used_count   = COUNT_FIELD_W'(taken_total);
  assign res.pool_full    = (taken_total == CNT_FULL);

endmodule

@@ hw/rtl/bsa_checker.sv @@
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] granted_slot,
  input logic [1:0] status,
  input logic       pool_full
);
  import bsa_pkg::*;

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(granted_slot) && $stable(status))
    else $error("result beat changed while stalled");

  // no new request while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request accepted while result pending");

  // exactly one result beat per request
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> !res_valid)
    else $error("repeated result beat");

  // a full-pool refusal reports a full pool and grants nothing
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_FULL |-> pool_full && granted_slot == 8'd0)
    else $error("pool full status inconsistent");

  // a failed free grants nothing
  a_not_taken_grant: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_NOT_TAKEN |-> granted_slot == 8'd0)
    else $error("failed free reports a granted slot");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .granted_slot (res.granted_slot),
  .status       (res.status),
  .pool_full    (res.pool_full)
);
